// ----- hw/rtl/tgc_pkg.sv -----
// types, constants and register reset values for the touch gesture classifier
// no dependencies; imported by tgc_classify and touch_gesture_classifier
`timescale 1ns / 1ps

package tgc_pkg;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int COORD_W     = 12;
   localparam int SIZE_W      = 13;
   localparam int TIME_W      = 32;
   localparam int MS_W        = 16;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIRROR_OFFSET  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS_MS  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_RADIUS    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SWIPE_DISTANCE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOUBLE_TAP_MS  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_PRESENT = 3'd7;

   typedef enum logic [2:0] {
      GEST_NONE   = 3'd0,
      GEST_TAP    = 3'd1,
      GEST_DOUBLE = 3'd2,
      GEST_LONG   = 3'd3,
      GEST_LEFT   = 3'd4,
      GEST_RIGHT  = 3'd5,
      GEST_UP     = 3'd6,
      GEST_DOWN   = 3'd7
   } gesture_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  screen_width;
      logic [SIZE_W-1:0]  screen_height;
      logic [COORD_W-1:0] mirror_offset;
      logic [MS_W-1:0]    long_press_ms;
      logic [COORD_W-1:0] hold_radius;
      logic [COORD_W-1:0] swipe_distance;
      logic [MS_W-1:0]    double_tap_ms;
      logic               device_present;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      screen_width:   13'd320,
      screen_height:  13'd170,
      mirror_offset:  12'd169,
      long_press_ms:  16'd850,
      hold_radius:    12'd18,
      swipe_distance: 12'd42,
      double_tap_ms:  16'd360,
      device_present: 1'b1
   };

   typedef struct packed {
      logic               read_ok;
      logic [3:0]         finger_count;
      logic [COORD_W-1:0] raw_x;
      logic [COORD_W-1:0] raw_y;
      logic [TIME_W-1:0]  now_ms;
   } item_type;

   typedef struct packed {
      gesture_type        gesture;
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
   } result_type;

   typedef struct packed {
      logic               was_down;
      logic               long_sent;
      logic [COORD_W-1:0] press_x;
      logic [COORD_W-1:0] press_y;
      logic [COORD_W-1:0] latest_x;
      logic [COORD_W-1:0] latest_y;
      logic [TIME_W-1:0]  press_time;
      logic [TIME_W-1:0]  last_tap_time;
   } state_type;

endpackage

// ----- hw/rtl/tgc_channels.sv -----
// valid/ready channel interfaces for touch polls and gesture results
// no dependencies; used by touch_gesture_classifier
`timescale 1ns / 1ps

interface tgc_req_if;
   logic        valid;
   logic        ready;
   logic        read_ok;
   logic [3:0]  finger_count;
   logic [11:0] raw_x;
   logic [11:0] raw_y;
   logic [31:0] now_ms;

   modport source (output valid, read_ok, finger_count, raw_x, raw_y, now_ms, input ready);
   modport sink   (input valid, read_ok, finger_count, raw_x, raw_y, now_ms, output ready);
endinterface

interface tgc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  gesture;
   logic [11:0] point_x;
   logic [11:0] point_y;

   modport source (output valid, gesture, point_x, point_y, input ready);
   modport sink   (input valid, gesture, point_x, point_y, output ready);
endinterface

// ----- hw/rtl/tgc_classify.sv -----
// combinational gesture decision: screen mapping, clamp, press/hold/release
// depends on tgc_pkg
`timescale 1ns / 1ps

module tgc_classify (
   input  tgc_pkg::cfg_type    cfg,
   input  tgc_pkg::item_type   item,
   input  tgc_pkg::state_type  state_cur,
   output tgc_pkg::result_type result,
   output tgc_pkg::state_type  state_nxt
);
   import tgc_pkg::*;

   logic                down;
   logic [SIZE_W-1:0]   top_x;
   logic [SIZE_W-1:0]   top_y;
   logic [SIZE_W-1:0]   y_diff;
   logic [COORD_W-1:0]  pos_x;
   logic [COORD_W-1:0]  pos_y;
   logic [SIZE_W-1:0]   hold_dx;
   logic [SIZE_W-1:0]   hold_dy;
   logic [COORD_W-1:0]  hold_adx;
   logic [COORD_W-1:0]  hold_ady;
   logic [TIME_W-1:0]   held_ms;
   logic                long_hit;
   logic [SIZE_W-1:0]   rel_dx;
   logic [SIZE_W-1:0]   rel_dy;
   logic [COORD_W-1:0]  rel_adx;
   logic [COORD_W-1:0]  rel_ady;
   logic [TIME_W-1:0]   tap_gap;
   logic                swipe;

   // clamp limits, zero size acts as one
   assign top_x = (cfg.screen_width == '0) ? '0 : cfg.screen_width - 1'b1;
   assign top_y = (cfg.screen_height == '0) ? '0 : cfg.screen_height - 1'b1;

   assign down = item.read_ok && (item.finger_count != '0);

   assign y_diff = {1'b0, cfg.mirror_offset} - {1'b0, item.raw_x};

   always_comb begin
      if ({1'b0, item.raw_y} > top_x) begin
         pos_x = top_x[COORD_W-1:0];
      end else begin
         pos_x = item.raw_y;
      end
      if (y_diff[SIZE_W-1]) begin
         pos_y = '0;
      end else if (y_diff > top_y) begin
         pos_y = top_y[COORD_W-1:0];
      end else begin
         pos_y = y_diff[COORD_W-1:0];
      end
   end

   // hold check against the current point
   assign hold_dx  = {1'b0, pos_x} - {1'b0, state_cur.press_x};
   assign hold_dy  = {1'b0, pos_y} - {1'b0, state_cur.press_y};
   assign hold_adx = hold_dx[SIZE_W-1] ? COORD_W'(-hold_dx) : hold_dx[COORD_W-1:0];
   assign hold_ady = hold_dy[SIZE_W-1] ? COORD_W'(-hold_dy) : hold_dy[COORD_W-1:0];
   assign held_ms  = item.now_ms - state_cur.press_time;
   assign long_hit = !state_cur.long_sent
                     && (held_ms > {{(TIME_W-MS_W){1'b0}}, cfg.long_press_ms})
                     && (hold_adx < cfg.hold_radius)
                     && (hold_ady < cfg.hold_radius);

   // release uses the last held point
   assign rel_dx  = {1'b0, state_cur.latest_x} - {1'b0, state_cur.press_x};
   assign rel_dy  = {1'b0, state_cur.latest_y} - {1'b0, state_cur.press_y};
   assign rel_adx = rel_dx[SIZE_W-1] ? COORD_W'(-rel_dx) : rel_dx[COORD_W-1:0];
   assign rel_ady = rel_dy[SIZE_W-1] ? COORD_W'(-rel_dy) : rel_dy[COORD_W-1:0];
   assign swipe   = (rel_adx > cfg.swipe_distance) || (rel_ady > cfg.swipe_distance);
   assign tap_gap = item.now_ms - state_cur.last_tap_time;

   always_comb begin
      result    = '{gesture: GEST_NONE, point_x: '0, point_y: '0};
      state_nxt = state_cur;
      if (cfg.device_present) begin
         if (down && !state_cur.was_down) begin
            state_nxt.was_down   = 1'b1;
            state_nxt.long_sent  = 1'b0;
            state_nxt.press_x    = pos_x;
            state_nxt.press_y    = pos_y;
            state_nxt.latest_x   = pos_x;
            state_nxt.latest_y   = pos_y;
            state_nxt.press_time = item.now_ms;
         end else if (down) begin
            state_nxt.latest_x = pos_x;
            state_nxt.latest_y = pos_y;
            if (long_hit) begin
               state_nxt.long_sent = 1'b1;
               result = '{gesture: GEST_LONG, point_x: pos_x, point_y: pos_y};
            end
         end else if (state_cur.was_down) begin
            state_nxt.was_down = 1'b0;
            if (!state_cur.long_sent) begin
               result.point_x = state_cur.latest_x;
               result.point_y = state_cur.latest_y;
               if (swipe) begin
                  // ties go to the vertical axis
                  if (rel_adx > rel_ady) begin
                     result.gesture = (!rel_dx[SIZE_W-1] && rel_dx != '0) ?
                                      GEST_RIGHT : GEST_LEFT;
                  end else begin
                     result.gesture = (!rel_dy[SIZE_W-1] && rel_dy != '0) ?
                                      GEST_DOWN : GEST_UP;
                  end
               end else if (tap_gap < {{(TIME_W-MS_W){1'b0}}, cfg.double_tap_ms}) begin
                  result.gesture          = GEST_DOUBLE;
                  state_nxt.last_tap_time = '0;
               end else begin
                  result.gesture          = GEST_TAP;
                  state_nxt.last_tap_time = item.now_ms;
               end
            end
         end
      end
   end

endmodule

// ----- hw/rtl/touch_gesture_classifier.sv -----
// touch gesture classifier top level: poll register, classifier, result register
// depends on tgc_pkg, tgc_channels (tgc_req_if, tgc_rsp_if) and tgc_classify
//
//   channel   dir  handshake        beat contents
//   req_ch    in   valid / ready    read_ok, finger_count, raw_x, raw_y, now_ms
//   rsp_ch    out  valid / ready    gesture, point_x, point_y
//   csr_*     in   csr_we only      csr_index selects register, csr_wdata value
//
// one poll per clock unless rsp_ch stalls; a poll beat first enters the poll register.
// classification sits between the poll register and the result register, and
// the tracking state updates in the same cycle the result is registered.
// reset (synchronous, high) clears state, valid flags and loads register defaults.
// a stalled rsp_ch holds its result; the poll register then fills and req_ch.ready drops.
`timescale 1ns / 1ps

module touch_gesture_classifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [tgc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tgc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   tgc_req_if.sink                            req_ch,
   tgc_rsp_if.source                          rsp_ch
);
   import tgc_pkg::*;

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   item_type   item_ff;
   result_type result_ff;
   result_type result_in;
   logic       poll_valid_ff;
   logic       rsp_valid_ff;
   logic       req_fire;
   logic       poll_move;

   assign poll_move    = poll_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !poll_valid_ff || poll_move;
   assign req_fire     = req_ch.valid && req_ch.ready;

   tgc_classify u_classify (
      .cfg       (cfg_ff),
      .item      (item_ff),
      .state_cur (state_ff),
      .result    (result_in),
      .state_nxt (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= CFG_RESET;
         state_ff      <= '0;
         poll_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:   cfg_ff.screen_width   <= csr_wdata[SIZE_W-1:0];
               CSR_SCREEN_HEIGHT:  cfg_ff.screen_height  <= csr_wdata[SIZE_W-1:0];
               CSR_MIRROR_OFFSET:  cfg_ff.mirror_offset  <= csr_wdata[COORD_W-1:0];
               CSR_LONG_PRESS_MS:  cfg_ff.long_press_ms  <= csr_wdata[MS_W-1:0];
               CSR_HOLD_RADIUS:    cfg_ff.hold_radius    <= csr_wdata[COORD_W-1:0];
               CSR_SWIPE_DISTANCE: cfg_ff.swipe_distance <= csr_wdata[COORD_W-1:0];
               CSR_DOUBLE_TAP_MS:  cfg_ff.double_tap_ms  <= csr_wdata[MS_W-1:0];
               CSR_DEVICE_PRESENT: cfg_ff.device_present <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_fire) begin
            poll_valid_ff <= 1'b1;
         end else if (poll_move) begin
            poll_valid_ff <= 1'b0;
         end
         if (poll_move) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.read_ok      <= req_ch.read_ok;
         item_ff.finger_count <= req_ch.finger_count;
         item_ff.raw_x        <= req_ch.raw_x;
         item_ff.raw_y        <= req_ch.raw_y;
         item_ff.now_ms       <= req_ch.now_ms;
      end
      if (poll_move) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.gesture = result_ff.gesture;
   assign rsp_ch.point_x = result_ff.point_x;
   assign rsp_ch.point_y = result_ff.point_y;

endmodule
